FILE: rtl/skt_pkg.sv
// Shared types and constants for the sorted key table.
`default_nettype none
package skt_pkg;

    localparam int unsigned TableDepthDefault = 128;
    localparam int unsigned QueueDepth = 2;

    localparam int unsigned KeyW = 32;
    localparam int unsigned NameAW = 64;
    localparam int unsigned NameBW = 64;
    localparam int unsigned NameCW = 32;
    localparam int unsigned PosW = 7;
    localparam int unsigned CountW = 8;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    // One command as it travels from the front end to the engine.
    typedef struct packed {
        cmd_t               command;
        logic [KeyW-1:0]    key;
        logic [NameAW-1:0]  name_a;
        logic [NameBW-1:0]  name_b;
        logic [NameCW-1:0]  name_c;
        logic [PosW-1:0]    read_index;
    } req_t;

    // One table record.
    typedef struct packed {
        logic [KeyW-1:0]    key;
        logic [NameAW-1:0]  name_a;
        logic [NameBW-1:0]  name_b;
        logic [NameCW-1:0]  name_c;
    } rec_t;

    // One result item.
    typedef struct packed {
        status_t            status;
        logic [PosW-1:0]    position;
        rec_t               rec;
        logic [CountW-1:0]  entry_count;
    } rsp_t;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_SCAN,
        ENG_SCAN_WAIT,
        ENG_SHIFT,
        ENG_WRITE,
        ENG_EMIT
    } eng_state_t;

endpackage
`default_nettype wire

FILE: rtl/skt_front.sv
// Front end: accepts commands and queues them for the table engine.
`default_nettype none
module skt_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire skt_pkg::req_t   in_req,
    output logic                 q_valid,
    input  wire logic            q_ready,
    output skt_pkg::req_t        q_req
);

    localparam int unsigned Depth = skt_pkg::QueueDepth;
    localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;

    skt_pkg::req_t     slot_reg [Depth];
    logic [IdxW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [IdxW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [IdxW:0]     used_reg, used_next;
    logic              push, pop;

    assign in_ready = (used_reg != (IdxW+1)'(Depth));
    assign q_valid  = (used_reg != '0);
    assign q_req    = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        used_next   = used_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IdxW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IdxW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            used_next = used_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            used_next = used_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            used_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            used_reg   <= used_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_req;
        end
    end

    // The queue never holds more than its depth.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= (IdxW+1)'(Depth))
        else $error("queue occupancy above depth");

    // A transfer in with none out raises the occupancy by one.
    a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (used_reg == $past(used_reg) + 1'b1))
        else $error("queue occupancy did not rise");

    // A transfer out with none in lowers the occupancy by one.
    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (used_reg == $past(used_reg) - 1'b1))
        else $error("queue occupancy did not fall");

endmodule
`default_nettype wire

FILE: rtl/skt_engine.sv
// Table engine: memory, search, shift and result register.
`default_nettype none
module skt_engine #(
    parameter int unsigned TABLE_DEPTH = skt_pkg::TableDepthDefault
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  wire skt_pkg::req_t   q_req,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output skt_pkg::rsp_t        out_rsp
);

    localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned FillW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned CmpW  = (FillW > skt_pkg::PosW) ? FillW : skt_pkg::PosW;

    skt_pkg::rec_t mem [TABLE_DEPTH];
    skt_pkg::rec_t rd_data_reg;

    skt_pkg::eng_state_t state_reg, state_next;
    skt_pkg::req_t       req_reg;
    logic [FillW-1:0]    fill_reg, fill_next;
    logic [FillW-1:0]    ptr_reg, ptr_next;
    logic [FillW-1:0]    pos_reg, pos_next;
    logic                out_valid_reg, out_valid_next;
    skt_pkg::rsp_t       out_rsp_reg, out_rsp_next;

    // Memory port controls.
    logic                rd_en;
    logic [AddrW-1:0]    rd_addr;
    logic                wr_en;
    logic [AddrW-1:0]    wr_addr;
    skt_pkg::rec_t       wr_data;

    logic                hit;
    logic                key_below;
    logic                read_in_range;
    skt_pkg::rec_t       new_rec;

    assign new_rec   = '{key: q_req.key, name_a: q_req.name_a,
                         name_b: q_req.name_b, name_c: q_req.name_c};
    assign hit       = (rd_data_reg.key == req_reg.key);
    assign key_below = ($signed(rd_data_reg.key) < $signed(req_reg.key));
    assign read_in_range = (CmpW'(req_reg.read_index) < CmpW'(fill_reg));
    assign q_ready   = (state_reg == skt_pkg::ENG_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skt_pkg::ENG_IDLE:
            begin
                if (q_valid && q_ready)
                begin
                    case (q_req.command)
                        skt_pkg::CMD_READ:
                            state_next = skt_pkg::ENG_SCAN_WAIT;
                        skt_pkg::CMD_INSERT:
                            state_next = (fill_reg >= FillW'(TABLE_DEPTH)) ?
                                skt_pkg::ENG_EMIT : skt_pkg::ENG_SCAN;
                        default:
                            state_next = skt_pkg::ENG_SCAN;
                    endcase
                end
            end
            skt_pkg::ENG_SCAN:
            begin
                if (ptr_reg < fill_reg)
                begin
                    state_next = skt_pkg::ENG_SCAN_WAIT;
                end
                else if (req_reg.command == skt_pkg::CMD_INSERT)
                begin
                    state_next = skt_pkg::ENG_WRITE;
                end
                else
                begin
                    state_next = skt_pkg::ENG_EMIT;
                end
            end
            skt_pkg::ENG_SCAN_WAIT:
            begin
                state_next = skt_pkg::ENG_SCAN;
                case (req_reg.command)
                    skt_pkg::CMD_INSERT:
                        if (!key_below) state_next = skt_pkg::ENG_SHIFT;
                    skt_pkg::CMD_LOOKUP:
                        if (hit) state_next = skt_pkg::ENG_EMIT;
                    skt_pkg::CMD_DELETE:
                        if (hit) state_next = skt_pkg::ENG_SHIFT;
                    default:
                        state_next = skt_pkg::ENG_EMIT;
                endcase
            end
            skt_pkg::ENG_SHIFT:
            begin
                state_next = skt_pkg::ENG_WRITE;
            end
            skt_pkg::ENG_WRITE:
            begin
                state_next = skt_pkg::ENG_EMIT;
                if (req_reg.command == skt_pkg::CMD_INSERT)
                begin
                    if (ptr_reg > pos_reg)
                    begin
                        state_next = (ptr_reg - 1'b1 > pos_reg) ? skt_pkg::ENG_SHIFT
                                                                : skt_pkg::ENG_WRITE;
                    end
                end
                else if (req_reg.command == skt_pkg::CMD_DELETE)
                begin
                    if (ptr_reg < fill_reg) state_next = skt_pkg::ENG_SHIFT;
                end
            end
            skt_pkg::ENG_EMIT:
            begin
                state_next = skt_pkg::ENG_IDLE;
            end
            default:
            begin
                state_next = skt_pkg::ENG_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    // Insert: scan up to the first key not below, ptr then runs down from
    // fill moving each entry up one slot (read in SHIFT, write in WRITE).
    // Delete: scan to the first hit, then ptr runs up moving entries down.
    always_comb
    begin
        fill_next      = fill_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_rsp_next   = out_rsp_reg;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg[AddrW-1:0];
        wr_en          = 1'b0;
        wr_addr        = ptr_reg[AddrW-1:0];
        wr_data        = rd_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            skt_pkg::ENG_IDLE:
            begin
                ptr_next = '0;
                pos_next = '0;
                if (q_valid && q_ready)
                begin
                    out_rsp_next.rec = new_rec;
                    out_rsp_next.status = skt_pkg::ST_OK;
                    if (q_req.command == skt_pkg::CMD_READ)
                    begin
                        ptr_next = FillW'(q_req.read_index);
                        rd_en    = 1'b1;
                        rd_addr  = AddrW'(q_req.read_index);
                    end
                    else if (q_req.command == skt_pkg::CMD_INSERT &&
                             fill_reg >= FillW'(TABLE_DEPTH))
                    begin
                        out_rsp_next.status = skt_pkg::ST_FULL;
                    end
                end
            end
            skt_pkg::ENG_SCAN:
            begin
                if (ptr_reg < fill_reg)
                begin
                    rd_en = 1'b1;
                end
                else if (req_reg.command == skt_pkg::CMD_INSERT)
                begin
                    pos_next = ptr_reg;
                    ptr_next = fill_reg;
                end
                else
                begin
                    out_rsp_next.status = skt_pkg::ST_NOT_FOUND;
                end
            end
            skt_pkg::ENG_SCAN_WAIT:
            begin
                case (req_reg.command)
                    skt_pkg::CMD_INSERT:
                    begin
                        if (!key_below)
                        begin
                            pos_next = ptr_reg;
                            ptr_next = fill_reg;
                        end
                        else
                        begin
                            ptr_next = ptr_reg + 1'b1;
                        end
                    end
                    skt_pkg::CMD_LOOKUP, skt_pkg::CMD_DELETE:
                    begin
                        if (hit)
                        begin
                            pos_next = ptr_reg;
                            out_rsp_next.rec = rd_data_reg;
                            ptr_next = ptr_reg + 1'b1;
                        end
                        else
                        begin
                            ptr_next = ptr_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        pos_next = ptr_reg;
                        if (read_in_range)
                        begin
                            out_rsp_next.rec = rd_data_reg;
                        end
                        else
                        begin
                            out_rsp_next.status = skt_pkg::ST_RANGE;
                        end
                    end
                endcase
            end
            skt_pkg::ENG_SHIFT:
            begin
                // Read the entry that moves: the neighbor below slot ptr on an insert, slot ptr itself on a delete.
                rd_en = 1'b1;
                if (req_reg.command == skt_pkg::CMD_INSERT)
                begin
                    rd_addr = AddrW'(ptr_reg - 1'b1);
                end
                else
                begin
                    rd_addr = ptr_reg[AddrW-1:0];
                end
            end
            skt_pkg::ENG_WRITE:
            begin
                if (req_reg.command == skt_pkg::CMD_INSERT)
                begin
                    if (ptr_reg > pos_reg)
                    begin
                        wr_en    = 1'b1;
                        ptr_next = ptr_reg - 1'b1;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_data = out_rsp_reg.rec;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                else if (req_reg.command == skt_pkg::CMD_DELETE)
                begin
                    if (ptr_reg < fill_reg)
                    begin
                        // Entry pulled down into its lower neighbor.
                        wr_en    = 1'b1;
                        wr_addr  = AddrW'(ptr_reg - 1'b1);
                        ptr_next = ptr_reg + 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_reg - 1'b1;
                    end
                end
            end
            skt_pkg::ENG_EMIT:
            begin
                out_valid_next = 1'b1;
                out_rsp_next.entry_count = skt_pkg::CountW'(fill_reg);
                if (out_rsp_reg.status == skt_pkg::ST_OK)
                begin
                    out_rsp_next.position = (req_reg.command == skt_pkg::CMD_DELETE) ?
                        skt_pkg::PosW'(req_reg.read_index) :
                        skt_pkg::PosW'(pos_reg);
                end
                else
                begin
                    out_rsp_next.position = '0;
                    out_rsp_next.rec      = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skt_pkg::ENG_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers. Delete keeps its hit position in the
    // spare read_index field of the held command.
    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        pos_reg     <= pos_next;
        out_rsp_reg <= out_rsp_next;
        if (state_reg == skt_pkg::ENG_IDLE && q_valid && q_ready)
        begin
            req_reg <= q_req;
        end
        else if (state_reg == skt_pkg::ENG_SCAN_WAIT &&
                 req_reg.command == skt_pkg::CMD_DELETE && hit)
        begin
            req_reg.read_index <= skt_pkg::PosW'(ptr_reg);
        end
    end

    // Table memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // The fill count never exceeds the table depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FillW'(TABLE_DEPTH))
        else $error("fill count above depth");

    // The fill count only moves by one, and only at the write step.
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != skt_pkg::ENG_WRITE) |=> $stable(fill_reg))
        else $error("fill count changed outside the write step");

    // A new command is never taken while a result waits.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !q_ready)
        else $error("command taken with a result pending");

endmodule
`default_nettype wire

FILE: rtl/sorted_key_table.sv
// Sorted key table top level: port unpacking around the front end and engine.
// Commands wait in the input queue before the engine takes them; an insert into a
// full table skips the scan and is answered with the full status.
// Commands are handled one at a time, the next taken the cycle after the result
// transfer.
// Reset: rst_n clears the fill count, queue and handshake state; the table
// memory holds no reset value and its contents are only returned below the fill count.
`default_nettype none
module sorted_key_table #(
    parameter int unsigned TABLE_DEPTH = skt_pkg::TableDepthDefault
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [1:0]   command,
    input  wire logic signed [31:0] key,
    input  wire logic [63:0]  name_word_a,
    input  wire logic [63:0]  name_word_b,
    input  wire logic [31:0]  name_word_c,
    input  wire logic [6:0]   read_index,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [1:0]        status,
    output logic [6:0]        position,
    output logic signed [31:0] found_key,
    output logic [63:0]       found_name_a,
    output logic [63:0]       found_name_b,
    output logic [31:0]       found_name_c,
    output logic [7:0]        entry_count
);

    skt_pkg::req_t in_req;
    skt_pkg::req_t q_req;
    skt_pkg::rsp_t out_rsp;
    logic          q_valid;
    logic          q_ready;

    assign in_req = '{command: skt_pkg::cmd_t'(command), key: key,
                      name_a: name_word_a, name_b: name_word_b,
                      name_c: name_word_c, read_index: read_index};

    skt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    skt_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_req     (q_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rsp   (out_rsp)
    );

    assign status       = out_rsp.status;
    assign position     = out_rsp.position;
    assign found_key    = out_rsp.rec.key;
    assign found_name_a = out_rsp.rec.name_a;
    assign found_name_b = out_rsp.rec.name_b;
    assign found_name_c = out_rsp.rec.name_c;
    assign entry_count  = out_rsp.entry_count;

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the sorted key table: random commands against a table predictor.
`timescale 1ns / 1ps
module tb_top;

    localparam int Depth = skt_pkg::TableDepthDefault;
    localparam int GapMax = 8;
    localparam int HoldCycles = 400;
    localparam int WatchdogLimit = 6000;
    localparam int TailCycles = 300;
    localparam int RandomItems = 1680;

    typedef struct {
        skt_pkg::cmd_t command;
        logic [31:0] key;
        logic [63:0] name_a;
        logic [63:0] name_b;
        logic [31:0] name_c;
        logic [6:0]  read_index;
        bit          wait_drain;
    } table_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] command = 2'd0;
    logic signed [31:0] key = '0;
    logic [63:0] name_word_a = '0;
    logic [63:0] name_word_b = '0;
    logic [31:0] name_word_c = '0;
    logic [6:0] read_index = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] status;
    logic [6:0] position;
    logic signed [31:0] found_key;
    logic [63:0] found_name_a;
    logic [63:0] found_name_b;
    logic [31:0] found_name_c;
    logic [7:0] entry_count;

    // Pending commands, and results the table is expected to return.
    table_cmd_t pending_cmds[$];
    table_cmd_t cur_cmd;
    skt_pkg::rsp_t expected_rsp[$];

    // Shadow copy of the table contents.
    logic signed [31:0] shadow_key[Depth];
    logic [63:0] shadow_a[Depth];
    logic [63:0] shadow_b[Depth];
    logic [31:0] shadow_c[Depth];
    int shadow_fill;

    logic [31:0] used_keys[$];
    int error_count;
    int sent_count;
    int send_gap;
    int recv_gap;
    int hold_left;
    bit hold_done;
    int idle_cycles = 0;

    sorted_key_table i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .key(key),
        .name_word_a(name_word_a), .name_word_b(name_word_b),
        .name_word_c(name_word_c), .read_index(read_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .position(position), .found_key(found_key),
        .found_name_a(found_name_a), .found_name_b(found_name_b),
        .found_name_c(found_name_c), .entry_count(entry_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Count one mismatch and print a line for it, up to the first 50.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= 50)
            $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    // Work out the result of one command and update the shadow table.
    task automatic predict_table_op(input table_cmd_t c);
        skt_pkg::rsp_t r;
        int pos;
        int j;
        r = '0;
        r.status = skt_pkg::ST_OK;
        pos = -1;
        case (c.command)
            skt_pkg::CMD_INSERT:
            begin
                if (shadow_fill >= Depth)
                    r.status = skt_pkg::ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < shadow_fill && shadow_key[pos] < $signed(c.key))
                        pos++;
                    for (j = shadow_fill; j > pos; j--)
                    begin
                        shadow_key[j] = shadow_key[j-1];
                        shadow_a[j] = shadow_a[j-1];
                        shadow_b[j] = shadow_b[j-1];
                        shadow_c[j] = shadow_c[j-1];
                    end
                    shadow_key[pos] = c.key;
                    shadow_a[pos] = c.name_a;
                    shadow_b[pos] = c.name_b;
                    shadow_c[pos] = c.name_c;
                    shadow_fill++;
                end
            end
            skt_pkg::CMD_LOOKUP, skt_pkg::CMD_DELETE:
            begin
                for (j = 0; j < shadow_fill && pos < 0; j++)
                    if (shadow_key[j] == $signed(c.key))
                        pos = j;
                if (pos < 0)
                    r.status = skt_pkg::ST_NOT_FOUND;
            end
            default:
            begin
                if (int'(c.read_index) < shadow_fill)
                    pos = c.read_index;
                else
                    r.status = skt_pkg::ST_RANGE;
            end
        endcase
        if (pos >= 0)
        begin
            r.position = pos[6:0];
            r.rec.key = shadow_key[pos];
            r.rec.name_a = shadow_a[pos];
            r.rec.name_b = shadow_b[pos];
            r.rec.name_c = shadow_c[pos];
        end
        // A delete closes the gap after its entry has been captured.
        if (c.command == skt_pkg::CMD_DELETE && pos >= 0)
        begin
            for (j = pos; j + 1 < shadow_fill; j++)
            begin
                shadow_key[j] = shadow_key[j+1];
                shadow_a[j] = shadow_a[j+1];
                shadow_b[j] = shadow_b[j+1];
                shadow_c[j] = shadow_c[j+1];
            end
            shadow_fill--;
        end
        r.entry_count = shadow_fill[7:0];
        expected_rsp.push_back(r);
    endtask

    function automatic table_cmd_t make_cmd(input skt_pkg::cmd_t op, input logic [31:0] k,
                                            input logic [6:0] idx);
        table_cmd_t c;
        c.command = op;
        c.key = k;
        c.name_a = {$urandom, $urandom};
        c.name_b = {$urandom, $urandom};
        c.name_c = $urandom;
        c.read_index = idx;
        c.wait_drain = 1'b0;
        return c;
    endfunction

    // Pick a key: mostly from a small pool or earlier inserts, so hits and ties occur.
    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && used_keys.size() > 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        else if (sel < 7)
            return 32'($signed($urandom_range(0, 40)) - 20);
        else if (sel == 7)
            return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
        return $urandom;
    endfunction

    // Driver: offers queued commands with random gaps and predicts each transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_table_op(cur_cmd);
                sent_count++;
            end
            if (in_valid && !in_ready)
                ;
            else if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].wait_drain && expected_rsp.size() > 0))
            begin
                cur_cmd = pending_cmds.pop_front();
                command <= cur_cmd.command;
                key <= cur_cmd.key;
                name_word_a <= cur_cmd.name_a;
                name_word_b <= cur_cmd.name_b;
                name_word_c <= cur_cmd.name_c;
                read_index <= cur_cmd.read_index;
                in_valid <= 1'b1;
                send_gap = ((sent_count % 500) < 80) ? 0 : $urandom_range(0, GapMax);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: random stalls, one long hold-off, field-by-field compare.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_rsp.size() == 0)
                    report_mismatch("unexpected transfer, status", status, 0);
                else
                begin
                    if (status !== expected_rsp[0].status)
                        report_mismatch("status", status, expected_rsp[0].status);
                    if (position !== expected_rsp[0].position)
                        report_mismatch("position", position, expected_rsp[0].position);
                    if (found_key !== expected_rsp[0].rec.key)
                        report_mismatch("found_key", found_key, expected_rsp[0].rec.key);
                    if (found_name_a !== expected_rsp[0].rec.name_a)
                        report_mismatch("found_name_a", found_name_a,
                                        expected_rsp[0].rec.name_a);
                    if (found_name_b !== expected_rsp[0].rec.name_b)
                        report_mismatch("found_name_b", found_name_b,
                                        expected_rsp[0].rec.name_b);
                    if (found_name_c !== expected_rsp[0].rec.name_c)
                        report_mismatch("found_name_c", found_name_c,
                                        expected_rsp[0].rec.name_c);
                    if (entry_count !== expected_rsp[0].entry_count)
                        report_mismatch("entry_count", entry_count,
                                        expected_rsp[0].entry_count);
                    void'(expected_rsp.pop_front());
                end
                recv_gap = ((sent_count % 500) < 80) ? 0 : $urandom_range(0, GapMax);
            end
            if (!hold_done && sent_count >= 250)
            begin
                hold_done = 1'b1;
                hold_left = HoldCycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus and end of test.
    initial
    begin
        table_cmd_t c;
        int i;
        int roll;
        bit fill_phase;
        skt_pkg::cmd_t op;
        error_count = 0;
        sent_count = 0;
        send_gap = 0;
        recv_gap = 0;
        hold_left = 0;
        hold_done = 1'b0;
        shadow_fill = 0;

        // Directed: empty table, extreme keys, ties, misses, out-of-range reads.
        pending_cmds.push_back(make_cmd(skt_pkg::CMD_READ, 32'd0, 7'd0));
        pending_cmds.push_back(make_cmd(skt_pkg::CMD_READ, 32'd0, 7'd127));
        pending_cmds.push_back(make_cmd(skt_pkg::CMD_LOOKUP, 32'd5, 7'd0));
        pending_cmds.push_back(make_cmd(skt_pkg::CMD_DELETE, 32'd5, 7'd0));
        pending_cmds.push_back(make_cmd(skt_pkg::CMD_INSERT, 32'h7fff_ffff, 7'd0));
        pending_cmds.push_back(make_cmd(skt_pkg::CMD_INSERT, 32'h8000_0000, 7'd0));
        pending_cmds.push_back(make_cmd(skt_pkg::CMD_INSERT, 32'd0, 7'd0));
        pending_cmds.push_back(make_cmd(skt_pkg::CMD_INSERT, 32'hffff_ffff, 7'd0));
        pending_cmds.push_back(make_cmd(skt_pkg::CMD_INSERT, 32'd0, 7'd0));
        c = make_cmd(skt_pkg::CMD_INSERT, 32'd1, 7'h7f);
        c.name_a = '1;
        c.name_b = '1;
        c.name_c = '1;
        pending_cmds.push_back(c);
        pending_cmds.push_back(make_cmd(skt_pkg::CMD_LOOKUP, 32'd0, 7'd0));
        pending_cmds.push_back(make_cmd(skt_pkg::CMD_LOOKUP, 32'h8000_0000, 7'd0));
        pending_cmds.push_back(make_cmd(skt_pkg::CMD_LOOKUP, 32'h7fff_ffff, 7'd0));
        for (i = 0; i < 7; i++)
            pending_cmds.push_back(make_cmd(skt_pkg::CMD_READ, 32'd0, i[6:0]));
        pending_cmds.push_back(make_cmd(skt_pkg::CMD_DELETE, 32'd0, 7'd0));
        pending_cmds.push_back(make_cmd(skt_pkg::CMD_DELETE, 32'h7fff_ffff, 7'd0));
        pending_cmds.push_back(make_cmd(skt_pkg::CMD_DELETE, 32'd12345, 7'd0));
        pending_cmds.push_back(make_cmd(skt_pkg::CMD_READ, 32'd0, 7'd4));
        used_keys.push_back(32'd0);
        used_keys.push_back(32'h8000_0000);
        used_keys.push_back(32'h7fff_ffff);

        // Random: alternating fill and drain phases so the table reaches full and empty.
        for (i = 0; i < RandomItems; i++)
        begin
            fill_phase = ((i / 400) % 2) == 0;
            roll = $urandom_range(0, 99);
            if (roll < (fill_phase ? 70 : 15))
                op = skt_pkg::CMD_INSERT;
            else if (roll < (fill_phase ? 80 : 70))
                op = skt_pkg::CMD_DELETE;
            else if (roll < 90)
                op = skt_pkg::CMD_LOOKUP;
            else
                op = skt_pkg::CMD_READ;
            c = make_cmd(op, pick_key(), 7'($urandom_range(0, 127)));
            if (op == skt_pkg::CMD_INSERT && used_keys.size() < 256)
                used_keys.push_back(c.key);
            c.wait_drain = (i == 0) || (i == 1000);
            pending_cmds.push_back(c);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Checked away from the rising edge, where the driver updates its queue.
        do
            @(negedge clk);
        while (!(pending_cmds.size() == 0 && !in_valid && expected_rsp.size() == 0));
        repeat (TailCycles) @(posedge clk);
        if (expected_rsp.size() != 0)
            report_mismatch("results left over, count", expected_rsp.size(), 0);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
